FILE: hw/rtl/picture_order_count_unit_assert.svh
// Assertion macros used by the picture order count RTL.
`ifndef PICTURE_ORDER_COUNT_UNIT_ASSERT_SVH
`define PICTURE_ORDER_COUNT_UNIT_ASSERT_SVH
// Same-cycle implication, checked out of reset.
`define PCU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcu assertion failed");
// Next-cycle implication, checked out of reset.
`define PCU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcu assertion failed");
`endif

FILE: hw/rtl/pcu_pkg.sv
// Package with types, codes and helpers of the picture order count unit.
`timescale 1ns / 1ps
package pcu_pkg;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ORDER_MODE  = 3'd0,
    REG_LOG2_LSB    = 3'd1,
    REG_LOG2_FRAME  = 3'd2,
    REG_CYCLE_LEN   = 3'd3,
    REG_NON_REF     = 3'd4,
    REG_TOP_BOT     = 3'd5
  } cfg_reg_t;

  localparam logic [1:0] MODE_LSB   = 2'd0;
  localparam logic [1:0] MODE_TABLE = 2'd1;
  localparam logic [1:0] MODE_FRAME = 2'd2;

  localparam logic [1:0] ST_TOP    = 2'd1;
  localparam logic [1:0] ST_BOTTOM = 2'd2;

  localparam logic [4:0] Log2Min = 5'd4;
  localparam logic [4:0] Log2Max = 5'd16;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
    logic [7:0]  rem;
  } div_res_t;

  function automatic logic [4:0] clamp_log2(input logic [4:0] v);
    logic [4:0] r;
    r = v;
    if (v < Log2Min) r = Log2Min;
    if (v > Log2Max) r = Log2Max;
    return r;
  endfunction
endpackage

FILE: hw/rtl/pcu_table.sv
// Offset table memory with per-entry valid bits and registered read.
`timescale 1ns / 1ps
module pcu_table #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);
  logic [31:0]      mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [31:0]      rd_word_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_word_r <= mem[rd_addr];
  end

  // Entries never written read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_word_r : 32'd0;
endmodule

FILE: hw/rtl/pcu_div.sv
// Serial restoring divider, 32-bit dividend by 8-bit divisor, one bit a cycle.
`timescale 1ns / 1ps
module pcu_div
  import pcu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [7:0]  divisor,
  output div_res_t    res
);
  logic [31:0] quo_r;
  logic [7:0]  rem_r;
  logic [7:0]  dsr_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [8:0]  trial;
  logic [8:0]  diff;

  assign trial = {rem_r, quo_r[31]};
  assign diff  = trial - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quo_r  <= dividend;
        rem_r  <= '0;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        if (trial >= {1'b0, dsr_r}) begin
          rem_r <= diff[7:0];
          quo_r <= {quo_r[30:0], 1'b1};
        end else begin
          rem_r <= trial[7:0];
          quo_r <= {quo_r[30:0], 1'b0};
        end
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.quo  = quo_r;
  assign res.rem  = rem_r;
endmodule

FILE: hw/rtl/picture_order_count_unit.sv
// Flow: a table load is written when accepted; modes zero, two and three pass through
// S_CALC and S_OUT before out_valid rises; mode one runs the serial divider, then S_WALK
// with one table read per cycle, S_MUL and S_FIN, or goes straight to S_FIN when the
// absolute frame number is zero. Throughput: loads one per cycle while idle; one picture
// at a time, the next accepted once the result has moved to the output register. Reset is
// synchronous, active low; clears state, config, history, out_valid and table valid bits.
`timescale 1ns / 1ps
`include "picture_order_count_unit_assert.svh"
module picture_order_count_unit
  import pcu_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_kind,
  input  logic                in_is_idr,
  input  logic                in_is_reference,
  input  logic [15:0]         in_frame_number,
  input  logic [15:0]         in_order_lsb,
  input  logic signed [31:0]  in_bottom_delta,
  input  logic signed [31:0]  in_first_delta,
  input  logic signed [31:0]  in_second_delta,
  input  logic [1:0]          in_structure,
  input  logic                in_resets_memory,
  input  logic [7:0]          in_table_slot,
  input  logic signed [31:0]  in_table_word,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_top_order,
  output logic signed [31:0]  out_bottom_order
);
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_CALC, S_DIV, S_WALK, S_MUL, S_FIN, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [1:0]  order_mode_r;
  logic [4:0]  log2_lsb_r;
  logic [4:0]  log2_frame_r;
  logic [7:0]  cycle_len_r;
  logic [31:0] non_ref_r;
  logic [31:0] top_bot_r;

  // Previous-picture state.
  logic [31:0] last_msb_r;
  logic [15:0] last_lsb_r;
  logic [31:0] last_foff_r;
  logic [15:0] last_fnum_r;
  logic        last_reset_r;

  // Captured picture.
  logic        idr_r, ref_r, mm5_r;
  logic [15:0] fnum_in_r, lsb_in_r;
  logic [31:0] dbot_r, d0_r, d1_r;
  logic [1:0]  st_r;

  // Mode one working registers.
  logic [31:0] cnt_r;
  logic [7:0]  pos_r;
  logic [8:0]  issue_r;
  logic        p_vld_r, p_in_r;
  logic [7:0]  p_idx_r;
  logic [31:0] full_r, part_r, prod_r;

  logic [31:0] res_top_r, res_bot_r;
  logic        out_valid_r;
  logic [31:0] out_top_r, out_bot_r;

  // Table and divider hookup.
  logic          tbl_we;
  logic [AW-1:0] tbl_waddr;
  logic [31:0]   tbl_rdata;
  logic          div_start;
  logic [31:0]   div_dend;
  div_res_t      div_res;

  logic in_acc;
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign tbl_we    = in_acc && in_kind && ({1'b0, in_table_slot} < 9'(TABLE_DEPTH));
  assign tbl_waddr = AW'(in_table_slot);

  pcu_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (tbl_we),
    .wr_addr (tbl_waddr),
    .wr_data (in_table_word),
    .rd_addr (issue_r[AW-1:0]),
    .rd_data (tbl_rdata)
  );

  pcu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dend),
    .divisor  (cycle_len_r),
    .res      (div_res)
  );

  // Per-picture arithmetic from the captured fields.
  logic [16:0] maxl, maxf, half;
  logic [15:0] lsb, fnum;
  logic [31:0] pmsb, msb, v0, bot0;
  logic [15:0] plsb;
  logic [16:0] dn, up;
  logic [31:0] poff, off, absn, t2;
  logic [15:0] pnum;

  always_comb begin
    maxl = 17'd1 << clamp_log2(log2_lsb_r);
    maxf = 17'd1 << clamp_log2(log2_frame_r);
    half = maxl >> 1;
    lsb  = lsb_in_r & 16'(maxl - 17'd1);
    fnum = fnum_in_r & 16'(maxf - 17'd1);

    pmsb = (!idr_r && !last_reset_r) ? last_msb_r : 32'd0;
    plsb = (!idr_r && !last_reset_r) ? last_lsb_r : 16'd0;
    dn   = {1'b0, plsb} - {1'b0, lsb};
    up   = {1'b0, lsb} - {1'b0, plsb};
    if (lsb < plsb && dn >= half) begin
      msb = pmsb + {15'd0, maxl};
    end else if (lsb > plsb && up > half) begin
      msb = pmsb - {15'd0, maxl};
    end else begin
      msb = pmsb;
    end
    v0   = msb + {16'd0, lsb};
    bot0 = (st_r == ST_TOP || st_r == ST_BOTTOM) ? v0 : v0 + dbot_r;

    poff = last_reset_r ? 32'd0 : last_foff_r;
    pnum = last_reset_r ? 16'd0 : last_fnum_r;
    if (idr_r) begin
      off = 32'd0;
    end else begin
      off = poff + ((pnum > fnum) ? {15'd0, maxf} : 32'd0);
    end
    absn = (cycle_len_r != 8'd0) ? off + {16'd0, fnum} : 32'd0;
    if (!ref_r && absn != 32'd0) begin
      absn = absn - 32'd1;
    end
    t2 = idr_r ? 32'd0 : (((off + {16'd0, fnum}) << 1) - {31'd0, !ref_r});
  end

  assign div_start = (state_r == S_CALC) && (order_mode_r == MODE_TABLE) && (absn != 32'd0);
  assign div_dend  = absn - 32'd1;

  // Final mode one sums.
  logic [31:0] expv, fin_top, fin_bot;
  always_comb begin
    expv = prod_r + part_r + (ref_r ? 32'd0 : non_ref_r);
    case (st_r)
      ST_TOP: begin
        fin_top = expv + d0_r;
        fin_bot = fin_top;
      end
      ST_BOTTOM: begin
        fin_bot = expv + top_bot_r + d0_r;
        fin_top = fin_bot;
      end
      default: begin
        fin_top = expv + d0_r;
        fin_bot = fin_top + top_bot_r + d1_r;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc && !in_kind) state_nxt = S_CALC;
      S_CALC: begin
        if (order_mode_r == MODE_TABLE) begin
          state_nxt = (absn != 32'd0) ? S_DIV : S_FIN;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DIV:  if (div_res.done) state_nxt = S_WALK;
      S_WALK: if (!p_vld_r && issue_r == {1'b0, cycle_len_r}) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_FIN;
      S_FIN:  state_nxt = S_OUT;
      S_OUT:  if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      order_mode_r <= MODE_LSB;
      log2_lsb_r   <= Log2Min;
      log2_frame_r <= Log2Min;
      cycle_len_r  <= '0;
      non_ref_r    <= '0;
      top_bot_r    <= '0;
      last_msb_r   <= '0;
      last_lsb_r   <= '0;
      last_foff_r  <= '0;
      last_fnum_r  <= '0;
      last_reset_r <= 1'b0;
      out_valid_r  <= 1'b0;
      p_vld_r      <= 1'b0;
      issue_r      <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_index)
          REG_ORDER_MODE: order_mode_r <= cfg_data[1:0];
          REG_LOG2_LSB:   log2_lsb_r   <= cfg_data[4:0];
          REG_LOG2_FRAME: log2_frame_r <= cfg_data[4:0];
          REG_CYCLE_LEN:  cycle_len_r  <= cfg_data[7:0];
          REG_NON_REF:    non_ref_r    <= cfg_data;
          REG_TOP_BOT:    top_bot_r    <= cfg_data;
          default: ;
        endcase
      end

      if (state_r == S_OUT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc && !in_kind) begin
            idr_r     <= in_is_idr;
            ref_r     <= in_is_reference;
            mm5_r     <= in_resets_memory;
            fnum_in_r <= in_frame_number;
            lsb_in_r  <= in_order_lsb;
            dbot_r    <= in_bottom_delta;
            d0_r      <= in_first_delta;
            d1_r      <= in_second_delta;
            st_r      <= in_structure;
          end
        end
        S_CALC: begin
          prod_r  <= '0;
          part_r  <= '0;
          full_r  <= '0;
          issue_r <= '0;
          p_vld_r <= 1'b0;
          case (order_mode_r)
            MODE_LSB: begin
              res_top_r <= v0;
              res_bot_r <= bot0;
              if (ref_r) begin
                last_msb_r   <= msb;
                last_lsb_r   <= lsb;
                last_reset_r <= mm5_r;
              end
            end
            MODE_TABLE: begin
              last_foff_r  <= off;
              last_fnum_r  <= fnum;
              last_reset_r <= mm5_r;
            end
            MODE_FRAME: begin
              res_top_r    <= t2;
              res_bot_r    <= t2;
              last_foff_r  <= off;
              last_fnum_r  <= fnum;
              last_reset_r <= mm5_r;
            end
            default: begin
              res_top_r <= '0;
              res_bot_r <= '0;
            end
          endcase
        end
        S_DIV: begin
          cnt_r <= div_res.quo;
          pos_r <= div_res.rem;
        end
        S_WALK: begin
          // One read issued per cycle; data returns in the next cycle.
          if (issue_r < {1'b0, cycle_len_r}) begin
            p_vld_r <= 1'b1;
            p_idx_r <= issue_r[7:0];
            p_in_r  <= issue_r < 9'(TABLE_DEPTH);
            issue_r <= issue_r + 9'd1;
          end else begin
            p_vld_r <= 1'b0;
          end
          if (p_vld_r && p_in_r) begin
            full_r <= full_r + tbl_rdata;
            if (p_idx_r <= pos_r) part_r <= part_r + tbl_rdata;
          end
        end
        S_MUL: prod_r <= cnt_r * full_r;
        S_FIN: begin
          res_top_r <= fin_top;
          res_bot_r <= fin_bot;
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_top_r   <= res_top_r;
            out_bot_r   <= res_bot_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_top_order    = out_top_r;
  assign out_bottom_order = out_bot_r;

  `PCU_ASSERT_NEXT(a_out_from_out_state, !out_valid_r && state_r != S_OUT, !out_valid_r)
  `PCU_ASSERT_NOW(a_div_done_in_div, div_res.done, state_r == S_DIV)
  `PCU_ASSERT_NOW(a_walk_below_len, p_vld_r, p_idx_r < cycle_len_r)
  `PCU_ASSERT_NOW(a_pos_below_len, state_r == S_WALK, pos_r < cycle_len_r)
endmodule
